// File: rtl/fbpa_pkg.sv
// Package for the fixed block pool allocator: field widths, item and status codes,
// register indexes, the controller state type and the command struct.
// Depends on nothing; every other file of the block refers to it by scoped name.
`default_nettype none

package fbpa_pkg;

   // Widths fixed by the port fields
   localparam int ADDR_PORT_W = 32;
   localparam int SIZE_W      = 16;
   localparam int COUNT_W     = 11;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int PROD_W      = COUNT_W + SIZE_W;

   typedef logic [ADDR_PORT_W-1:0] addr_port_type;
   typedef logic [SIZE_W-1:0]      size_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [MODE_W-1:0]      mode_type;
   typedef logic [STATUS_W-1:0]    status_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [PROD_W-1:0]      prod_type;

   // Item modes; the unused code behaves as a check
   localparam mode_type MODE_ALLOC = 2'd0;
   localparam mode_type MODE_FREE  = 2'd1;
   localparam mode_type MODE_CHECK = 2'd2;

   // Result status codes
   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_EMPTY   = 2'd1;
   localparam status_type STATUS_OUTSIDE = 2'd2;
   localparam status_type STATUS_FULL    = 2'd3;

   // Register indexes
   localparam csr_index_type CSR_BASE_ADDRESS = 2'd0;
   localparam csr_index_type CSR_BLOCK_BYTES  = 2'd1;
   localparam csr_index_type CSR_ENTRY_COUNT  = 2'd2;

   // Register reset values
   localparam addr_port_type RESET_BASE_ADDRESS = 32'd0;
   localparam size_type      RESET_BLOCK_BYTES  = 16'd64;
   localparam count_type     RESET_ENTRY_COUNT  = 11'd1024;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_DECIDE,
      S_REPORT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic multiply;
      logic add;
      logic decide;
      logic report;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/fbpa_ctrl.sv
// Controller of the fixed block pool allocator: a five-state sequencer that steps
// one item through multiply, add, decide and report. Depends on fbpa_pkg.
`default_nettype none

module fbpa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output fbpa_pkg::cmd_type     cmd
);

   fbpa_pkg::state_type state_ff;
   fbpa_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbpa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: an item runs straight through the four work steps.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbpa_pkg::S_IDLE: begin
            if (start) begin
               state_in = fbpa_pkg::S_MUL;
            end
         end
         fbpa_pkg::S_MUL:    state_in = fbpa_pkg::S_ADD;
         fbpa_pkg::S_ADD:    state_in = fbpa_pkg::S_DECIDE;
         fbpa_pkg::S_DECIDE: state_in = fbpa_pkg::S_REPORT;
         fbpa_pkg::S_REPORT: state_in = fbpa_pkg::S_IDLE;
         default:            state_in = fbpa_pkg::S_IDLE;
      endcase
   end

   // Outputs: one command per state.
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         fbpa_pkg::S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         fbpa_pkg::S_MUL:    cmd.multiply = 1'b1;
         fbpa_pkg::S_ADD:    cmd.add      = 1'b1;
         fbpa_pkg::S_DECIDE: cmd.decide   = 1'b1;
         fbpa_pkg::S_REPORT: cmd.report   = 1'b1;
         default:            busy         = 1'b0;
      endcase
   end

   // The sequence must not skip a step once an item has been taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == fbpa_pkg::S_MUL)
      else $error("item taken but multiply step not entered");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == fbpa_pkg::S_DECIDE |=> cmd.report)
      else $error("decide step not followed by report");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

endmodule

`default_nettype wire

// File: rtl/fbpa_dp.sv
// Datapath of the fixed block pool allocator: configuration registers, the freed
// address stack memory, the usage counters and the result registers.
// Depends on fbpa_pkg; driven by commands from fbpa_ctrl.
`default_nettype none

module fbpa_dp #(
   parameter int CAPACITY     = 1024,
   parameter int ADDRESS_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire fbpa_pkg::cmd_type        cmd,
   input  wire logic                     csr_write_enable,
   input  wire fbpa_pkg::csr_index_type  csr_index,
   input  wire fbpa_pkg::csr_data_type   csr_write_data,
   input  wire fbpa_pkg::mode_type       req_mode,
   input  wire fbpa_pkg::addr_port_type  req_block_address,
   output logic                          rsp_valid,
   output fbpa_pkg::addr_port_type       rsp_given_address,
   output fbpa_pkg::status_type          rsp_status,
   output logic                          rsp_in_pool,
   output logic                          rsp_exhausted,
   output fbpa_pkg::count_type           rsp_free_count
);

   localparam int AW     = ADDRESS_BITS;
   localparam int DW     = $clog2(CAPACITY + 1);
   localparam int IW     = $clog2(CAPACITY);
   localparam int FREE_W = $clog2(CAPACITY + 2048);

   // Configuration registers
   fbpa_pkg::addr_port_type base_address_ff;
   fbpa_pkg::size_type      block_bytes_ff;
   fbpa_pkg::count_type     entry_count_ff;

   // Pool state
   logic [DW-1:0]       freed_depth_ff, freed_depth_in;
   fbpa_pkg::count_type fresh_used_ff, fresh_used_in;
   logic [AW-1:0]       stack_mem [CAPACITY];
   logic [AW-1:0]       stack_rd_ff;

   // Item and intermediate registers
   fbpa_pkg::mode_type  mode_ff;
   logic [AW-1:0]       addr_ff;
   fbpa_pkg::count_type n_ff;
   logic [FREE_W-1:0]   free_ff;
   fbpa_pkg::prod_type  last_prod_ff;
   fbpa_pkg::prod_type  fresh_prod_ff;
   logic [AW-1:0]       base_ff;
   logic [AW-1:0]       last_ff;
   logic [AW-1:0]       fresh_addr_ff;

   // Result registers
   logic                    rsp_valid_ff;
   fbpa_pkg::addr_port_type rsp_given_ff, rsp_given_in;
   fbpa_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic                    rsp_in_pool_ff, rsp_in_pool_in;
   logic                    rsp_exhausted_ff;
   fbpa_pkg::count_type     rsp_free_count_ff;

   // Combinational helpers
   fbpa_pkg::count_type n_now;
   fbpa_pkg::count_type fresh_avail;
   logic [FREE_W-1:0]   free_now;
   logic [DW-1:0]       depth_m1;
   logic                in_pool;
   logic                push;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= fbpa_pkg::RESET_BASE_ADDRESS;
         block_bytes_ff  <= fbpa_pkg::RESET_BLOCK_BYTES;
         entry_count_ff  <= fbpa_pkg::RESET_ENTRY_COUNT;
      end else if (csr_write_enable) begin
         case (csr_index)
            fbpa_pkg::CSR_BASE_ADDRESS: base_address_ff <= csr_write_data;
            fbpa_pkg::CSR_BLOCK_BYTES:  block_bytes_ff  <= fbpa_pkg::size_type'(csr_write_data);
            fbpa_pkg::CSR_ENTRY_COUNT:  entry_count_ff  <= fbpa_pkg::count_type'(csr_write_data);
            default: ;
         endcase
      end
   end

   // Pool size is the entry count limited to the stack capacity.
   always_comb begin
      if (32'(entry_count_ff) > 32'(CAPACITY)) begin
         n_now = fbpa_pkg::count_type'(CAPACITY);
      end else begin
         n_now = entry_count_ff;
      end
   end

   // Free entries: the untouched fresh part plus the freed addresses on the stack.
   assign fresh_avail = (fresh_used_ff < n_now) ? (n_now - fresh_used_ff) : '0;
   assign free_now    = FREE_W'(fresh_avail) + FREE_W'(freed_depth_ff);

   // Stack memory: the top entry is read every cycle, a push writes in the decide step.
   assign depth_m1 = freed_depth_ff - DW'(1);

   always_ff @(posedge clock) begin
      stack_rd_ff <= stack_mem[depth_m1[IW-1:0]];
      if (cmd.decide && push) begin
         stack_mem[freed_depth_ff[IW-1:0]] <= addr_ff;
      end
   end

   // Item capture, the two products and the two address sums.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         addr_ff <= AW'(req_block_address);
      end
      if (cmd.multiply) begin
         n_ff          <= n_now;
         free_ff       <= free_now;
         base_ff       <= AW'(base_address_ff);
         last_prod_ff  <= (n_now - fbpa_pkg::count_type'(1)) * block_bytes_ff;
         fresh_prod_ff <= fresh_used_ff * block_bytes_ff;
      end
      if (cmd.add) begin
         last_ff       <= base_ff + AW'(last_prod_ff);
         fresh_addr_ff <= base_ff + AW'(fresh_prod_ff);
      end
   end

   // Range test; a wrapped last address leaves the range empty.
   assign in_pool = (n_ff != '0) && (addr_ff >= base_ff) && (addr_ff <= last_ff);

   // Decision for the item held in the registers.
   always_comb begin
      freed_depth_in = freed_depth_ff;
      fresh_used_in  = fresh_used_ff;
      rsp_given_in   = '0;
      rsp_status_in  = fbpa_pkg::STATUS_OK;
      rsp_in_pool_in = in_pool;
      push           = 1'b0;
      case (mode_ff)
         fbpa_pkg::MODE_ALLOC: begin
            if (freed_depth_ff != '0) begin
               freed_depth_in = depth_m1;
               rsp_given_in   = fbpa_pkg::addr_port_type'(stack_rd_ff);
            end else if (fresh_used_ff < n_ff) begin
               fresh_used_in = fresh_used_ff + fbpa_pkg::count_type'(1);
               rsp_given_in  = fbpa_pkg::addr_port_type'(fresh_addr_ff);
            end else begin
               rsp_status_in = fbpa_pkg::STATUS_EMPTY;
            end
         end
         fbpa_pkg::MODE_FREE: begin
            if ((free_ff >= FREE_W'(n_ff)) || (32'(freed_depth_ff) >= 32'(CAPACITY))) begin
               rsp_status_in = fbpa_pkg::STATUS_FULL;
            end else if (!in_pool) begin
               rsp_status_in = fbpa_pkg::STATUS_OUTSIDE;
            end else begin
               push           = 1'b1;
               freed_depth_in = freed_depth_ff + DW'(1);
            end
         end
         default: ;
      endcase
   end

   // Pool counters
   always_ff @(posedge clock) begin
      if (reset) begin
         freed_depth_ff <= '0;
         fresh_used_ff  <= '0;
      end else if (cmd.decide) begin
         freed_depth_ff <= freed_depth_in;
         fresh_used_ff  <= fresh_used_in;
      end
   end

   // Result registers: address, status and range in the decide step, counts after it.
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_given_ff   <= rsp_given_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_in_pool_ff <= rsp_in_pool_in;
      end
      if (cmd.report) begin
         rsp_exhausted_ff  <= (free_now == '0);
         rsp_free_count_ff <= fbpa_pkg::count_type'(free_now);
      end
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.report;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_given_address = rsp_given_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_in_pool       = rsp_in_pool_ff;
   assign rsp_exhausted     = rsp_exhausted_ff;
   assign rsp_free_count    = rsp_free_count_ff;

   // The stack never holds more than its capacity.
   assert property (@(posedge clock) disable iff (reset)
      freed_depth_ff <= DW'(CAPACITY))
      else $error("freed stack depth beyond capacity");

   // A refused item hands out no address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != fbpa_pkg::STATUS_OK) |-> rsp_given_ff == '0)
      else $error("address given with an error status");

   // Only a successful free grows the stack, by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      cmd.decide && (mode_ff == fbpa_pkg::MODE_FREE) && (rsp_status_in == fbpa_pkg::STATUS_OK)
      |=> freed_depth_ff == $past(freed_depth_ff) + DW'(1))
      else $error("successful free did not push the stack");

endmodule

`default_nettype wire

// File: rtl/fixed_block_pool_allocator.sv
// Fixed block pool allocator: one item in work at a time. An item is taken
// when start is high and busy low; its single result appears on the rsp_ ports for
// exactly one cycle, marked by rsp_valid, and the receiver cannot stall it. Busy
// stays high while the item is in the work steps, so the next item can be taken in
// the cycle the result is shown. The steps, sequenced by fbpa_ctrl, are the
// entry-size multiplications, the address additions, the range compares with the
// registered read of the freed stack memory and the update, then the free-count sum.
// The freed stack needs no clearing after reset, so items are taken from the first
// cycle after reset. The user must write the registers through the csr_ port only
// while busy is low; the block itself does not enforce it.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_dp.
`default_nettype none

module fixed_block_pool_allocator #(
   parameter int CAPACITY     = 1024,
   parameter int ADDRESS_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire fbpa_pkg::csr_index_type  csr_index,
   input  wire fbpa_pkg::csr_data_type   csr_write_data,
   input  wire logic                     start,
   output logic                          busy,
   input  wire fbpa_pkg::mode_type       req_mode,
   input  wire fbpa_pkg::addr_port_type  req_block_address,
   output logic                          rsp_valid,
   output fbpa_pkg::addr_port_type       rsp_given_address,
   output fbpa_pkg::status_type          rsp_status,
   output logic                          rsp_in_pool,
   output logic                          rsp_exhausted,
   output fbpa_pkg::count_type           rsp_free_count
);

   fbpa_pkg::cmd_type cmd;

   // Sequencer
   fbpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Registers, stack memory and result path
   fbpa_dp #(
      .CAPACITY     (CAPACITY),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_mode          (req_mode),
      .req_block_address (req_block_address),
      .rsp_valid         (rsp_valid),
      .rsp_given_address (rsp_given_address),
      .rsp_status        (rsp_status),
      .rsp_in_pool       (rsp_in_pool),
      .rsp_exhausted     (rsp_exhausted),
      .rsp_free_count    (rsp_free_count)
   );

   // Every item taken gives its result, marked by rsp_valid.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##5 rsp_valid)
      else $error("item taken without a result five cycles later");

   // An item taken makes the block busy in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after taking an item");

   // A result is shown only once the block is free for the next item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while an item is still in work");

endmodule

`default_nettype wire
